FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the filter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every clock edge outside of reset.
`define RHM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a condition never holds outside of reset.
`define RHM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/rhm_pkg.sv
// ----------------------------------------------------------------------------
// Median filter package
// Types, constants and helpers shared by the median filter modules.
// ----------------------------------------------------------------------------
package rhm_pkg;

  localparam int GRAY_LEVELS = 256;
  localparam int GRAY_W = 8;
  localparam int BIN_W = 6;
  localparam int ROW_W = 12;
  localparam int COL_W = 10;
  localparam int IW_W = 11;
  localparam int WIN_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 12;

  localparam int DEF_MAX_LINE_WIDTH = 1024;
  localparam int DEF_MAX_WINDOW = 7;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 2'd3;

  localparam logic [IW_W-1:0] RST_IMAGE_WIDTH = 11'd640;
  localparam logic [ROW_W-1:0] RST_IMAGE_HEIGHT = 12'd480;
  localparam logic [WIN_W-1:0] RST_WINDOW = 3'd3;

  typedef struct packed {
    logic [GRAY_W-1:0] pixel;
    logic              frame_start;
  } pix_word_t;

  typedef struct packed {
    logic [GRAY_W-1:0] median_value;
    logic [ROW_W-1:0]  center_row;
    logic [COL_W-1:0]  center_col;
    logic              last_of_frame;
  } res_word_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_word_t;

  typedef struct packed {
    logic              clear;
    logic [GRAY_W-1:0] rd_addr;
    logic              wr_en;
    logic [GRAY_W-1:0] wr_addr;
    logic [BIN_W-1:0]  wr_data;
  } hist_req_t;

  function automatic logic [WIN_W-1:0] fit_window(input logic [WIN_W-1:0] v,
                                                  input logic [WIN_W-1:0] top);
    logic [WIN_W-1:0] r;
    r = v;
    if (r == '0) begin
      r = 3'd1;
    end
    if (!r[0]) begin
      r = r + 3'd1;
    end
    if (r > top) begin
      r = top;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/rhm_stream_if.sv
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel that carries one word of a given type.
// ----------------------------------------------------------------------------
interface rhm_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/rhm_hist.sv
// ----------------------------------------------------------------------------
// Histogram store
// Gray-level bin counts with per-bin valid bits so that a clear empties every bin at once.
// ----------------------------------------------------------------------------
module rhm_hist
  import rhm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hist_req_t        req_i,
  output logic [BIN_W-1:0] rd_data_o
);

  logic [BIN_W-1:0]       mem [GRAY_LEVELS];
  logic [GRAY_LEVELS-1:0] valid_q;
  logic [BIN_W-1:0]       rd_q;
  logic                   rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    rd_q <= mem[req_i.rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= valid_q[req_i.rd_addr];
      if (req_i.clear) begin
        valid_q <= '0;
      end else if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_q : '0;

endmodule

FILE: hw/rtl/running_histogram_median_filter_top.sv
// ----------------------------------------------------------------------------
// Running histogram median filter
// Exact median of an odd window over a raster stream of 8-bit gray pixels.
// ----------------------------------------------------------------------------
// The block takes one pixel word at a time and is busy until that pixel is
// done. A pixel outside the rows that complete a window needs no step beyond
// its acceptance. Any other pixel steps through a line store read, histogram
// read and histogram write (LRD, HRD, HWR) for each window row it adds and,
// once the window is full width, first for each row it removes. A pixel that
// completes a window then settles the median: a check (DCHK), then a read and
// a subtract (DRD, DSUB) for each gray level the median moves down and a read
// and a check (URD, UCHK) for each level it moves up. It hands over the result
// in EMIT, which waits while an earlier result word is still waiting. Register
// writes take effect at the next frame.
`include "assert_macros.svh"

module running_histogram_median_filter_top
  import rhm_pkg::*;
#(
  parameter int MAX_LINE_WIDTH = DEF_MAX_LINE_WIDTH,
  parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
  input logic          clk_i,
  input logic          rst_ni,
  rhm_stream_if.sink   pix_i,
  rhm_stream_if.sink   cfg_i,
  rhm_stream_if.source res_o
);

  localparam int WinTopRaw = (MAX_WINDOW - 1) | 1;
  localparam logic [WIN_W-1:0] WinTop = WIN_W'((WinTopRaw > 7) ? 7 : WinTopRaw);
  localparam int SlotW = $clog2(MAX_WINDOW);
  localparam int SumW = $clog2(2 * MAX_WINDOW) + 1;
  localparam int AddrW = $clog2(MAX_WINDOW * MAX_LINE_WIDTH);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LRD  = 4'd1;
  localparam logic [3:0] ST_HRD  = 4'd2;
  localparam logic [3:0] ST_HWR  = 4'd3;
  localparam logic [3:0] ST_DCHK = 4'd4;
  localparam logic [3:0] ST_DRD  = 4'd5;
  localparam logic [3:0] ST_DSUB = 4'd6;
  localparam logic [3:0] ST_URD  = 4'd7;
  localparam logic [3:0] ST_UCHK = 4'd8;
  localparam logic [3:0] ST_EMIT = 4'd9;

  logic [3:0]        state_q, state_d;
  logic [IW_W-1:0]   reg_w_q;
  logic [ROW_W-1:0]  reg_h_q;
  logic [WIN_W-1:0]  reg_ww_q, reg_wh_q;
  logic [IW_W-1:0]   act_w_q, w_eff;
  logic [ROW_W-1:0]  act_h_q, h_eff;
  logic [WIN_W-1:0]  act_ww_q, act_wh_q, ww_eff, wh_eff;
  logic [ROW_W-1:0]  row_q, cur_row_q, r0;
  logic [IW_W-1:0]   col_q, cur_col_q, c0;
  logic [SlotW-1:0]  slot_q, cur_slot_q, s0;
  logic [WIN_W-1:0]  k_q;
  logic              remove_q;
  logic [GRAY_W-1:0] med_q, val_q, ls_rdata_q;
  logic [BIN_W-1:0]  below_q, hist_rd, thr;
  logic [5:0]        win_area;
  logic              pix_acc, latch_now;
  logic [SumW-1:0]   slot_sum;
  logic [SlotW-1:0]  rd_slot;
  logic [IW_W-1:0]   rd_col;
  logic [AddrW-1:0]  ls_waddr, ls_raddr;
  logic [GRAY_W-1:0] ls_mem [MAX_WINDOW * MAX_LINE_WIDTH];
  hist_req_t         hreq;
  res_word_t         res_q;
  logic              res_valid_q;
  logic              emit_go;

  assign pix_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign pix_acc = pix_i.valid && pix_i.ready;
  assign res_o.valid = res_valid_q;
  assign res_o.data = res_q;
  assign emit_go = (state_q == ST_EMIT) && (!res_valid_q || res_o.ready);

  assign r0 = pix_i.data.frame_start ? '0 : row_q;
  assign c0 = pix_i.data.frame_start ? '0 : col_q;
  assign s0 = pix_i.data.frame_start ? '0 : slot_q;
  assign latch_now = (r0 == '0) && (c0 == '0);

  always_comb begin
    w_eff  = act_w_q;
    h_eff  = act_h_q;
    ww_eff = act_ww_q;
    wh_eff = act_wh_q;
    if (latch_now) begin
      w_eff = (reg_w_q == '0) ? IW_W'(1) : reg_w_q;
      if ({21'd0, w_eff} > MAX_LINE_WIDTH) begin
        w_eff = IW_W'(MAX_LINE_WIDTH);
      end
      h_eff  = (reg_h_q == '0) ? ROW_W'(1) : reg_h_q;
      ww_eff = fit_window(reg_ww_q, WinTop);
      wh_eff = fit_window(reg_wh_q, WinTop);
    end
  end

  assign win_area = 6'(act_ww_q * act_wh_q);
  assign thr = win_area >> 1;

  assign slot_sum = SumW'(cur_slot_q) + SumW'(MAX_WINDOW + 1) + SumW'(k_q) - SumW'(act_wh_q);
  assign rd_slot = (slot_sum >= SumW'(MAX_WINDOW)) ? SlotW'(slot_sum - SumW'(MAX_WINDOW))
                                                   : SlotW'(slot_sum);
  assign rd_col = remove_q ? (cur_col_q - IW_W'(act_ww_q)) : cur_col_q;
  assign ls_raddr = AddrW'(AddrW'(rd_slot) * AddrW'(MAX_LINE_WIDTH)) + AddrW'(rd_col);
  assign ls_waddr = AddrW'(AddrW'(s0) * AddrW'(MAX_LINE_WIDTH)) + AddrW'(c0);

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      ls_mem[ls_waddr] <= pix_i.data.pixel;
    end
    ls_rdata_q <= ls_mem[ls_raddr];
  end

  always_comb begin
    hreq.clear   = pix_acc && (c0 == '0);
    hreq.rd_addr = ls_rdata_q;
    hreq.wr_en   = (state_q == ST_HWR);
    hreq.wr_addr = val_q;
    hreq.wr_data = remove_q ? ((hist_rd != '0) ? hist_rd - BIN_W'(1) : hist_rd)
                            : hist_rd + BIN_W'(1);
    case (state_q)
      ST_DRD:  hreq.rd_addr = med_q - GRAY_W'(1);
      ST_URD:  hreq.rd_addr = med_q;
      default: hreq.rd_addr = ls_rdata_q;
    endcase
  end

  rhm_hist u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (hreq),
    .rd_data_o (hist_rd)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (pix_acc && ({1'b0, r0} + 13'd1 >= 13'(wh_eff))) begin
          state_d = ST_LRD;
        end
      end
      ST_LRD:  state_d = ST_HRD;
      ST_HRD:  state_d = ST_HWR;
      ST_HWR: begin
        if (k_q != act_wh_q - 3'd1 || remove_q) begin
          state_d = ST_LRD;
        end else if ({1'b0, cur_col_q} + 12'd1 >= 12'(act_ww_q)) begin
          state_d = ST_DCHK;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DCHK: state_d = (below_q > thr && med_q != '0) ? ST_DRD : ST_URD;
      ST_DRD:  state_d = ST_DSUB;
      ST_DSUB: state_d = ST_DCHK;
      ST_URD:  state_d = ST_UCHK;
      ST_UCHK: begin
        if (med_q != GRAY_W'(GRAY_LEVELS - 1)
            && ({1'b0, below_q} + {1'b0, hist_rd} <= {1'b0, thr})) begin
          state_d = ST_URD;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: state_d = emit_go ? ST_IDLE : ST_EMIT;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      reg_w_q     <= RST_IMAGE_WIDTH;
      reg_h_q     <= RST_IMAGE_HEIGHT;
      reg_ww_q    <= RST_WINDOW;
      reg_wh_q    <= RST_WINDOW;
      act_w_q     <= RST_IMAGE_WIDTH;
      act_h_q     <= RST_IMAGE_HEIGHT;
      act_ww_q    <= RST_WINDOW;
      act_wh_q    <= RST_WINDOW;
      row_q       <= '0;
      col_q       <= '0;
      slot_q      <= '0;
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      cur_slot_q  <= '0;
      k_q         <= '0;
      remove_q    <= 1'b0;
      med_q       <= '0;
      below_q     <= '0;
      val_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        case (cfg_i.data.index)
          REG_IMAGE_WIDTH:   reg_w_q <= cfg_i.data.value[IW_W-1:0];
          REG_IMAGE_HEIGHT:  reg_h_q <= cfg_i.data.value[ROW_W-1:0];
          REG_WINDOW_WIDTH:  reg_ww_q <= cfg_i.data.value[WIN_W-1:0];
          REG_WINDOW_HEIGHT: reg_wh_q <= cfg_i.data.value[WIN_W-1:0];
          default: ;
        endcase
      end
      if (pix_acc) begin
        act_w_q    <= w_eff;
        act_h_q    <= h_eff;
        act_ww_q   <= ww_eff;
        act_wh_q   <= wh_eff;
        cur_row_q  <= r0;
        cur_col_q  <= c0;
        cur_slot_q <= s0;
        k_q        <= '0;
        remove_q   <= (c0 >= IW_W'(ww_eff));
        if (c0 == '0) begin
          med_q   <= '0;
          below_q <= '0;
        end
        if (c0 + IW_W'(1) >= w_eff) begin
          col_q <= '0;
          if ({1'b0, r0} + 13'd1 >= {1'b0, h_eff}) begin
            row_q  <= '0;
            slot_q <= '0;
          end else begin
            row_q  <= r0 + ROW_W'(1);
            slot_q <= (s0 == SlotW'(MAX_WINDOW - 1)) ? '0 : s0 + SlotW'(1);
          end
        end else begin
          col_q  <= c0 + IW_W'(1);
          row_q  <= r0;
          slot_q <= s0;
        end
      end
      case (state_q)
        ST_HRD: val_q <= ls_rdata_q;
        ST_HWR: begin
          if (remove_q) begin
            if (val_q < med_q && below_q != '0) begin
              below_q <= below_q - BIN_W'(1);
            end
          end else if (val_q < med_q) begin
            below_q <= below_q + BIN_W'(1);
          end
          if (k_q == act_wh_q - 3'd1) begin
            k_q      <= '0;
            remove_q <= 1'b0;
          end else begin
            k_q <= k_q + 3'd1;
          end
        end
        ST_DRD:  med_q <= med_q - GRAY_W'(1);
        ST_DSUB: below_q <= below_q - hist_rd;
        ST_UCHK: begin
          if (state_d == ST_URD) begin
            below_q <= below_q + hist_rd;
            med_q   <= med_q + GRAY_W'(1);
          end
        end
        default: ;
      endcase
      if (emit_go) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      res_q.median_value  <= med_q;
      res_q.center_row    <= cur_row_q - ROW_W'(act_wh_q >> 1);
      res_q.center_col    <= COL_W'(cur_col_q - IW_W'(act_ww_q >> 1));
      res_q.last_of_frame <= ({1'b0, cur_row_q} + 13'd1 == {1'b0, act_h_q})
                             && ({1'b0, cur_col_q} + 12'd1 == {1'b0, act_w_q});
    end
  end

  `RHM_ASSERT(a_median_settled, (state_q == ST_EMIT) |-> (below_q <= thr), "median not settled at emit")
  `RHM_ASSERT_NEVER(a_row_index, (state_q != ST_IDLE) && (k_q >= act_wh_q), "window row index out of range")
  `RHM_ASSERT(a_row_start_clear, (pix_acc && c0 == '0) |=> (med_q == '0 && below_q == '0), "histogram state not cleared at row start")

endmodule

FILE: sim/running_histogram_median_filter_top_test.sv
// ----------------------------------------------------------------------------
// Running histogram median filter testbench
// Drives raster pixel streams through the filter under several image and
// window settings. A local model of the window histogram predicts each
// median word, and every output word is checked against it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module running_histogram_median_filter_top_test;
  import rhm_pkg::*;

  localparam int LINE_MAX = DEF_MAX_LINE_WIDTH;
  localparam int WIN_MAX = DEF_MAX_WINDOW;
  localparam int STORE_ROWS = WIN_MAX - 1;
  localparam int SETTLE_CYCLES = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rhm_stream_if #(.T(pix_word_t)) pix_if ();
  rhm_stream_if #(.T(cfg_word_t)) cfg_if ();
  rhm_stream_if #(.T(res_word_t)) res_if ();

  running_histogram_median_filter_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  always #5 clk_i = ~clk_i;

  // Model state.
  int unsigned reg_w, reg_h, reg_ww, reg_wh;
  int unsigned cur_w, cur_h, cur_ww, cur_wh;
  byte unsigned line_mem [STORE_ROWS][LINE_MAX];
  int unsigned gray_bins [GRAY_LEVELS];
  int unsigned col_strips [WIN_MAX][WIN_MAX];
  int unsigned med_level, below_cnt, row_pos, col_pos;

  res_word_t median_q [$];
  int unsigned fail_cnt = 0;
  int unsigned pixels_sent = 0;
  int unsigned medians_seen = 0;
  int unsigned configs_done = 0;

  function automatic int unsigned odd_window(int unsigned v);
    int unsigned r;
    r = v & 7;
    if (r == 0) r = 1;
    if ((r & 1) == 0) r++;
    if (r > WIN_MAX) r = WIN_MAX;
    return r;
  endfunction

  task automatic latch_settings();
    cur_w = (reg_w == 0) ? 1 : reg_w;
    if (cur_w > LINE_MAX) cur_w = LINE_MAX;
    cur_h = (reg_h == 0) ? 1 : reg_h;
    cur_ww = odd_window(reg_ww);
    cur_wh = odd_window(reg_wh);
  endtask

  task automatic model_reset();
    reg_w = 32'(RST_IMAGE_WIDTH);
    reg_h = 32'(RST_IMAGE_HEIGHT);
    reg_ww = 32'(RST_WINDOW);
    reg_wh = 32'(RST_WINDOW);
    latch_settings();
    foreach (gray_bins[i]) gray_bins[i] = 0;
    foreach (col_strips[i, j]) col_strips[i][j] = 0;
    foreach (line_mem[i, j]) line_mem[i][j] = 0;
    med_level = 0;
    below_cnt = 0;
    row_pos = 0;
    col_pos = 0;
  endtask

  task automatic bin_add(int unsigned v);
    gray_bins[v]++;
    if (v < med_level) below_cnt++;
  endtask

  task automatic bin_remove(int unsigned v);
    if (gray_bins[v] > 0) gray_bins[v]--;
    if (v < med_level && below_cnt > 0) below_cnt--;
  endtask

  task automatic predict_median(input logic [GRAY_W-1:0] pix, input logic fs);
    int unsigned r, c, slot, v, rr, half;
    res_word_t w;
    if (fs) begin
      row_pos = 0;
      col_pos = 0;
    end
    if (row_pos == 0 && col_pos == 0) latch_settings();
    if (col_pos == 0) begin
      foreach (gray_bins[i]) gray_bins[i] = 0;
      med_level = 0;
      below_cnt = 0;
    end
    r = row_pos;
    c = col_pos;
    if (r + 1 >= cur_wh) begin
      if (c >= cur_ww) begin
        slot = (c - cur_ww) % WIN_MAX;
        for (int k = 0; k < cur_wh; k++) bin_remove(col_strips[slot][k]);
      end
      slot = c % WIN_MAX;
      for (int k = 0; k < cur_wh; k++) begin
        if (k + 1 == cur_wh) begin
          v = 32'(pix);
        end else begin
          rr = r + 1 - cur_wh + k;
          v = 32'(line_mem[rr % STORE_ROWS][c]);
        end
        col_strips[slot][k] = v;
        bin_add(v);
      end
      if (c + 1 >= cur_ww) begin
        half = (cur_ww * cur_wh) / 2;
        while (below_cnt > half && med_level > 0) begin
          med_level--;
          below_cnt -= gray_bins[med_level];
        end
        while (med_level + 1 < GRAY_LEVELS && below_cnt + gray_bins[med_level] <= half) begin
          below_cnt += gray_bins[med_level];
          med_level++;
        end
        w.median_value = med_level[GRAY_W-1:0];
        w.center_row = ROW_W'(r - cur_wh / 2);
        w.center_col = COL_W'(c - cur_ww / 2);
        w.last_of_frame = (r + 1 == cur_h && c + 1 == cur_w);
        median_q.push_back(w);
      end
    end
    line_mem[r % STORE_ROWS][c] = pix;
    col_pos++;
    if (col_pos >= cur_w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= cur_h) row_pos = 0;
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 4);
    return $urandom_range(15, 60);
  endfunction

  task automatic send_pixel(input logic [GRAY_W-1:0] pix, input logic fs);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.data <= '{pixel: pix, frame_start: fs};
    do @(posedge clk_i); while (!pix_if.ready);
    predict_median(pix, fs);
    pixels_sent++;
  endtask

  task automatic drain();
    pix_if.valid <= 1'b0;
    wait (median_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= '{index: idx, value: CFG_DATA_W'(value)};
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      REG_IMAGE_WIDTH: reg_w = value & 32'h7FF;
      REG_IMAGE_HEIGHT: reg_h = value & 32'hFFF;
      REG_WINDOW_WIDTH: reg_ww = value & 7;
      REG_WINDOW_HEIGHT: reg_wh = value & 7;
      default: ;
    endcase
    configs_done++;
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h, int unsigned ww, int unsigned wh);
    drain();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_WINDOW_WIDTH, ww);
    write_reg(REG_WINDOW_HEIGHT, wh);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [GRAY_W-1:0] pick_pixel(int unsigned mode);
    case (mode)
      0: return $urandom_range(1) ? 8'hFF : 8'h00;
      1: return GRAY_W'($urandom_range(120, 135));
      default: return GRAY_W'($urandom_range(255));
    endcase
  endfunction

  task automatic test_point_window();
    set_geometry(2047, 1, 0, 0);
    send_pixel(8'h00, 1'b1);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h55, 1'b0);
    send_pixel(8'hAA, 1'b0);
  endtask

  task automatic test_tall_column();
    set_geometry(1, 4095, 1, 2);
    send_pixel(8'hFF, 1'b1);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h80, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h01, 1'b0);
  endtask

  task automatic test_window_too_big();
    set_geometry(3, 3, 7, 6);
    for (int i = 0; i < 9; i++) send_pixel(pick_pixel(2), i == 0);
  endtask

  task automatic test_early_frame_start();
    set_geometry(3, 0, 4, 1);
    send_pixel(8'h10, 1'b1);
    send_pixel(8'hF0, 1'b0);
    send_pixel(8'h20, 1'b1);
    for (int i = 0; i < 4; i++) send_pixel(pick_pixel(0), 1'b0);
  endtask

  task automatic test_random_frames();
    int unsigned w, h, mode, npix, frames, eff_w, eff_h;
    while (pixels_sent < 1300) begin
      w = $urandom_range(1, 14);
      h = $urandom_range(1, 10);
      case ($urandom_range(9))
        0: w = $urandom_range(1) ? 0 : $urandom_range(1024, 2047);
        1: h = $urandom_range(1) ? 0 : 4095;
        default: ;
      endcase
      set_geometry(w, h, $urandom_range(7), $urandom_range(7));
      eff_w = (reg_w == 0) ? 1 : reg_w;
      if (eff_w > LINE_MAX) eff_w = LINE_MAX;
      eff_h = (reg_h == 0) ? 1 : reg_h;
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        mode = $urandom_range(3);
        npix = eff_w * eff_h;
        if (npix > 200) npix = $urandom_range(20, 200);
        if ($urandom_range(9) == 0) npix = $urandom_range(1, npix);
        for (int i = 0; i < npix; i++) begin
          send_pixel(pick_pixel(mode), (i == 0) && (f == 0 || $urandom_range(3) != 0));
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned hold;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      hold = 0;
    end else if (hold > 0) begin
      hold--;
      res_if.ready <= 1'b0;
    end else begin
      hold = pick_gap();
      res_if.ready <= (hold == 0);
    end
  end

  always @(posedge clk_i) begin
    res_word_t exp_w;
    if (rst_ni && res_if.valid && res_if.ready) begin
      medians_seen++;
      if (median_q.size() == 0) begin
        $error("Unexpected median word %p", res_if.data);
        fail_cnt++;
      end else begin
        exp_w = median_q.pop_front();
        if (res_if.data.median_value !== exp_w.median_value) begin
          $error("median_value: expected %0d, actual %0d", exp_w.median_value,
                 res_if.data.median_value);
          fail_cnt++;
        end
        if (res_if.data.center_row !== exp_w.center_row) begin
          $error("center_row: expected %0d, actual %0d", exp_w.center_row,
                 res_if.data.center_row);
          fail_cnt++;
        end
        if (res_if.data.center_col !== exp_w.center_col) begin
          $error("center_col: expected %0d, actual %0d", exp_w.center_col,
                 res_if.data.center_col);
          fail_cnt++;
        end
        if (res_if.data.last_of_frame !== exp_w.last_of_frame) begin
          $error("last_of_frame: expected %0d, actual %0d", exp_w.last_of_frame,
                 res_if.data.last_of_frame);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    pix_if.valid <= 1'b0;
    pix_if.data <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    model_reset();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_point_window();
    test_tall_column();
    test_window_too_big();
    test_early_frame_start();
    test_random_frames();
    drain();
    $display("Sent %0d pixel words over %0d register writes.", pixels_sent, configs_done);
    $display("Checked %0d median words, %0d mismatches.", medians_seen, fail_cnt);
    if (fail_cnt == 0 && median_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
